// ----- hdl/fua_pkg.sv -----
// ---------------------------------------------------------------------------
// fua_pkg
// shared types and constants for the h.264 rtp fu-a packetizer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fua_pkg;

   localparam int LenWidth      = 17;
   localparam int HeadWidth     = 40;
   localparam int SeqWidth      = 16;
   localparam int StampWidth    = 32;
   localparam int OffWidth      = 16;
   localparam int PayWidth      = 11;
   localparam int StepWidth     = 16;
   localparam int CsrIdxWidth   = 1;
   localparam int CsrDataWidth  = 16;
   localparam int ReqDataWidth  = 64;
   localparam int RspDataWidth  = 96;
   localparam int RspUserWidth  = 2;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_PAYLOAD    = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_TIMESTAMP_STEP = 1'd1;

   localparam logic [PayWidth-1:0]   MAX_PAYLOAD_RST    = 11'd1300;
   localparam logic [StepWidth-1:0]  TIMESTAMP_STEP_RST = 16'd3750;
   localparam logic [PayWidth-1:0]   PAYLOAD_MIN        = 11'd1100;
   localparam logic [PayWidth-1:0]   PAYLOAD_MAX        = 11'd1400;

   localparam logic [7:0] FU_INDICATOR_BYTE = 8'h7C;
   localparam logic [7:0] FU_START_BIT      = 8'h80;
   localparam logic [7:0] FU_END_BIT        = 8'h40;

   // kind of work handed from front to back
   localparam logic [1:0] KIND_SHORT  = 2'd0;
   localparam logic [1:0] KIND_SINGLE = 2'd1;
   localparam logic [1:0] KIND_FRAG   = 2'd2;

   typedef struct packed {
      logic [1:0]          kind;
      logic [2:0]          start_off;  // 0 (short) or 3..5
      logic [OffWidth-1:0] count;      // nal bytes (single) or bytes after nal header
      logic [4:0]          nal_type;
      logic [PayWidth-1:0] lim;        // clamped max payload
   } desc_type;

endpackage

// ----- hdl/fua_front.sv -----
// ---------------------------------------------------------------------------
// fua_front
// accepts frame descriptors, finds the start code and classifies the frame
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fua_front #(
   parameter int MAX_FRAME_BYTES = 65536
) (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fua_pkg::LenWidth-1:0]      frame_length,
   input  logic [fua_pkg::HeadWidth-1:0]     head_bytes,
   input  logic [fua_pkg::PayWidth-1:0]      max_payload,
   input  logic                              queue_ready,
   output logic                              push,
   output fua_pkg::desc_type                 desc
);
   import fua_pkg::*;

   localparam logic [LenWidth-1:0] MaxLen = LenWidth'(MAX_FRAME_BYTES);

   logic                is_short;
   logic                sep4;
   logic [LenWidth-1:0] len_c;
   logic [2:0]          sep;
   logic [7:0]          nal_hdr;
   logic [LenWidth-1:0] nal_len;
   logic [PayWidth-1:0] lim;
   logic                single;

   assign req_tready = queue_ready;
   assign push       = req_tvalid & queue_ready;

   always_comb begin
      is_short = frame_length < LenWidth'(5);
      len_c    = (frame_length > MaxLen) ? MaxLen : frame_length;
      sep4     = head_bytes[39:8] == 32'h0000_0001;
      sep      = sep4 ? 3'd4 : 3'd3;
      nal_hdr  = sep4 ? head_bytes[7:0] : head_bytes[15:8];
      nal_len  = len_c - LenWidth'(sep);
      if (max_payload < PAYLOAD_MIN) begin
         lim = PAYLOAD_MIN;
      end else if (max_payload > PAYLOAD_MAX) begin
         lim = PAYLOAD_MAX;
      end else begin
         lim = max_payload;
      end
      single = nal_len <= LenWidth'(lim);

      desc.nal_type = nal_hdr[4:0];
      desc.lim      = lim;
      if (is_short) begin
         desc.kind      = KIND_SHORT;
         desc.start_off = 3'd0;
         desc.count     = '0;
      end else if (single) begin
         desc.kind      = KIND_SINGLE;
         desc.start_off = sep;
         desc.count     = nal_len[OffWidth-1:0];
      end else begin
         // fragments skip the nal header byte
         desc.kind      = KIND_FRAG;
         desc.start_off = sep + 3'd1;
         desc.count     = nal_len[OffWidth-1:0] - OffWidth'(1);
      end
   end

endmodule

// ----- hdl/fua_queue.sv -----
// ---------------------------------------------------------------------------
// fua_queue
// two-entry queue of classified frames between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fua_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fua_pkg::desc_type push_desc,
   output logic              ready,
   input  logic              pop,
   output logic              not_empty,
   output fua_pkg::desc_type pop_desc
);
   import fua_pkg::*;

   desc_type   mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign ready     = count_ff != 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_desc  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ----- hdl/fua_back.sv -----
// ---------------------------------------------------------------------------
// fua_back
// cuts one classified frame into packet descriptors, one per cycle while rsp_tready does not stall
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fua_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 not_empty,
   input  fua_pkg::desc_type                    pop_desc,
   output logic                                 pop,
   input  logic [fua_pkg::StepWidth-1:0]        timestamp_step,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fua_pkg::RspDataWidth-1:0]     rsp_tdata,
   output logic [fua_pkg::RspUserWidth-1:0]     rsp_tuser,
   output logic                                 rsp_tlast
);
   import fua_pkg::*;

   // work registers
   logic                  busy_ff,  busy_in;
   logic                  first_ff, first_in;
   logic [1:0]            kind_ff,  kind_in;
   logic [OffWidth-1:0]   off_ff,   off_in;
   logic [OffWidth-1:0]   rest_ff,  rest_in;
   logic [4:0]            type_ff,  type_in;
   logic [PayWidth-1:0]   lim_ff,   lim_in;
   logic [SeqWidth-1:0]   seq_ff,   seq_in;
   logic [StampWidth-1:0] stamp_ff, stamp_in;

   // output register
   logic                    valid_ff, valid_in;
   logic [RspDataWidth-1:0] data_ff,  data_in;
   logic [RspUserWidth-1:0] user_ff,  user_in;
   logic                    last_ff,  last_in;

   logic                load;
   logic [OffWidth-1:0] piece_raw;
   logic [OffWidth-1:0] piece;
   logic                frag_last;
   logic                done;
   logic [OffWidth-1:0] r_off;
   logic [PayWidth-1:0] r_len;
   logic [7:0]          r_ind;
   logic [7:0]          r_hdr;
   logic                r_frag;
   logic                r_short;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   assign pop  = ~busy_ff & not_empty;
   assign load = busy_ff & (~valid_ff | rsp_tready);

   always_comb begin
      piece_raw = (rest_ff < OffWidth'(lim_ff)) ? rest_ff : OffWidth'(lim_ff);
      // a lone fragment would carry start and end: split off its last byte
      piece     = (first_ff && piece_raw == rest_ff) ? rest_ff - OffWidth'(1) : piece_raw;
      frag_last = piece == rest_ff;

      r_off   = '0;
      r_len   = '0;
      r_ind   = '0;
      r_hdr   = '0;
      r_frag  = 1'b0;
      r_short = 1'b0;
      done    = 1'b1;
      case (kind_ff)
         KIND_SHORT: begin
            r_short = 1'b1;
         end
         KIND_SINGLE: begin
            r_off = off_ff;
            r_len = rest_ff[PayWidth-1:0];
         end
         KIND_FRAG: begin
            r_off  = off_ff;
            r_len  = piece[PayWidth-1:0];
            r_ind  = FU_INDICATOR_BYTE;
            r_hdr  = {3'b000, type_ff} | (first_ff ? FU_START_BIT : 8'h00)
                     | (frag_last ? FU_END_BIT : 8'h00);
            r_frag = 1'b1;
            done   = frag_last;
         end
         default: begin
            r_short = 1'b1;
         end
      endcase
   end

   always_comb begin
      busy_in  = busy_ff;
      first_in = first_ff;
      kind_in  = kind_ff;
      off_in   = off_ff;
      rest_in  = rest_ff;
      type_in  = type_ff;
      lim_in   = lim_ff;
      seq_in   = seq_ff;
      stamp_in = stamp_ff;
      valid_in = valid_ff & ~rsp_tready;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;

      if (pop) begin
         busy_in  = 1'b1;
         first_in = 1'b1;
         kind_in  = pop_desc.kind;
         off_in   = OffWidth'(pop_desc.start_off);
         rest_in  = pop_desc.count;
         type_in  = pop_desc.nal_type;
         lim_in   = pop_desc.lim;
      end

      if (load) begin
         valid_in = 1'b1;
         data_in  = {5'b00000, r_hdr, r_ind, r_len, r_off, stamp_ff, seq_ff};
         user_in  = {r_short, r_frag};
         last_in  = done;
         first_in = 1'b0;
         off_in   = off_ff + piece;
         rest_in  = rest_ff - piece;
         if (!r_short) begin
            seq_in = seq_ff + SeqWidth'(1);
         end
         if (done) begin
            busy_in = 1'b0;
            if (!r_short) begin
               stamp_in = stamp_ff + StampWidth'(timestamp_step);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         seq_ff   <= '0;
         stamp_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         seq_ff   <= seq_in;
         stamp_ff <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      kind_ff  <= kind_in;
      off_ff   <= off_in;
      rest_ff  <= rest_in;
      type_ff  <= type_in;
      lim_ff   <= lim_in;
      data_ff  <= data_in;
      user_ff  <= user_in;
      last_ff  <= last_in;
   end

endmodule

// ----- hdl/h264_rtp_fua_packetizer.sv -----
// ---------------------------------------------------------------------------
// h264_rtp_fua_packetizer
// turns h.264 annex b frame descriptors into rtp packet descriptors
// ---------------------------------------------------------------------------
// path: the first packet descriptor of an accepted frame passes through the queue,
//   the back end work registers and its output register before rsp_tvalid
// throughput: the back end takes a frame from the queue, then gives one packet
//   per cycle while the receiver does not stall; up to 60 packets per frame
// the two-entry queue lets up to two classified frames wait behind the back end
// reset (synchronous, active high) clears sequence number and timestamp to zero
//   and restores the default max payload and timestamp step
`timescale 1ns / 1ps

module h264_rtp_fua_packetizer #(
   parameter int MAX_FRAME_BYTES = 65536
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // frame descriptor channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [16:0] frame_length, [56:17] head_bytes, rest zero
   input  logic [fua_pkg::ReqDataWidth-1:0]     req_tdata,
   // packet descriptor channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] sequence_res, [47:16] stamp, [63:48] payload_offset,
   // [74:64] payload_length, [82:75] fu_indicator, [90:83] fu_header, rest zero
   output logic [fua_pkg::RspDataWidth-1:0]     rsp_tdata,
   // [0] fragmented, [1] too_short
   output logic [fua_pkg::RspUserWidth-1:0]     rsp_tuser,
   output logic                                 rsp_tlast,   // last_packet
   // configuration writes
   input  logic                                 csr_we,
   input  logic [fua_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [fua_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import fua_pkg::*;

   // configuration registers
   logic [PayWidth-1:0]  max_payload_ff, max_payload_in;
   logic [StepWidth-1:0] ts_step_ff,     ts_step_in;

   // front to queue
   logic     push;
   desc_type push_desc;
   logic     queue_ready;

   // queue to back
   logic     pop;
   logic     not_empty;
   desc_type pop_desc;

   always_comb begin
      max_payload_in = max_payload_ff;
      ts_step_in     = ts_step_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_PAYLOAD:    max_payload_in = csr_wdata[PayWidth-1:0];
            CSR_TIMESTAMP_STEP: ts_step_in     = csr_wdata[StepWidth-1:0];
            default: begin
               max_payload_in = max_payload_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RST;
         ts_step_ff     <= TIMESTAMP_STEP_RST;
      end else begin
         max_payload_ff <= max_payload_in;
         ts_step_ff     <= ts_step_in;
      end
   end

   // front: start code detection, length clamp, single vs fragmented
   fua_front #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .frame_length (req_tdata[LenWidth-1:0]),
      .head_bytes   (req_tdata[LenWidth+HeadWidth-1:LenWidth]),
      .max_payload  (max_payload_ff),
      .queue_ready  (queue_ready),
      .push         (push),
      .desc         (push_desc)
   );

   // decouples classification from packet generation
   fua_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .ready     (queue_ready),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_desc  (pop_desc)
   );

   // back: one packet descriptor per cycle while rsp_tready allows, owns sequence and timestamp
   fua_back u_back (
      .clock          (clock),
      .reset          (reset),
      .not_empty      (not_empty),
      .pop_desc       (pop_desc),
      .pop            (pop),
      .timestamp_step (ts_step_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast)
   );

endmodule

// ----- sim/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the h.264 rtp fu-a packetizer: frame descriptors
// go in, every packet descriptor that comes out is compared with a packet
// plan worked out inside the bench from the register settings, the running
// sequence number and the running timestamp
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   import fua_pkg::*;

   localparam int FrameCap   = 65536;  // frame bytes beyond this are dropped
   localparam int StallLimit = 5000;   // cycles with no transaction at all
   localparam int ShowLimit  = 10;     // mismatches reported in full

   // one packet descriptor as it should leave the block
   typedef struct packed {
      logic [SeqWidth-1:0]   seq;
      logic [StampWidth-1:0] stamp;
      logic [OffWidth-1:0]   offset;
      logic [PayWidth-1:0]   length;
      logic [7:0]            fu_ind;
      logic [7:0]            fu_hdr;
      logic                  frag;
      logic                  too_short;
      logic                  last;
   } packet_type;

   // packet plan per frame, packets still owed by the block, mismatch count
   class packet_ledger_type;
      packet_type            owed[$];
      logic [PayWidth-1:0]   max_payload_reg;
      logic [StepWidth-1:0]  stamp_step_reg;
      logic [SeqWidth-1:0]   seq_next;
      logic [StampWidth-1:0] stamp_now;
      int unsigned           failures;

      function new();
         max_payload_reg = MAX_PAYLOAD_RST;
         stamp_step_reg  = TIMESTAMP_STEP_RST;
         seq_next        = '0;
         stamp_now       = '0;
         failures        = 0;
      endfunction

      function void write_reg(logic [CsrIdxWidth-1:0] idx, logic [CsrDataWidth-1:0] value);
         if (idx == CSR_MAX_PAYLOAD) begin
            max_payload_reg = value[PayWidth-1:0];
         end else begin
            stamp_step_reg = value[StepWidth-1:0];
         end
      endfunction

      // register value pulled into the legal payload window
      function int unsigned payload_limit();
         if (max_payload_reg < PAYLOAD_MIN) return 32'(PAYLOAD_MIN);
         if (max_payload_reg > PAYLOAD_MAX) return 32'(PAYLOAD_MAX);
         return 32'(max_payload_reg);
      endfunction

      function void push_packet(int unsigned off, int unsigned len, logic [7:0] ind,
                                logic [7:0] hdr, logic frag, logic too_short, logic last);
         packet_type p;
         p.seq       = seq_next;
         p.stamp     = stamp_now;
         p.offset    = off[OffWidth-1:0];
         p.length    = len[PayWidth-1:0];
         p.fu_ind    = ind;
         p.fu_hdr    = hdr;
         p.frag      = frag;
         p.too_short = too_short;
         p.last      = last;
         owed.push_back(p);
         // the error answer does not use up a sequence number
         if (!too_short) seq_next = seq_next + SeqWidth'(1);
      endfunction

      // plan the packets of one accepted frame
      function void note_frame(logic [LenWidth-1:0] frame_len, logic [HeadWidth-1:0] head);
         int unsigned flen, lim, sep, nal_len, rest, piece, off, n;
         logic [7:0]  nal_hdr, hdr;
         if (frame_len < 5) begin
            push_packet(0, 0, 8'h00, 8'h00, 1'b0, 1'b1, 1'b1);
            return;
         end
         flen    = (frame_len > FrameCap) ? FrameCap : 32'(frame_len);
         lim     = payload_limit();
         sep     = (head[39:8] == 32'h0000_0001) ? 4 : 3;
         nal_hdr = (sep == 4) ? head[7:0] : head[15:8];
         nal_len = flen - sep;
         if (nal_len <= lim) begin
            push_packet(sep, nal_len, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
         end else begin
            // nal header byte skipped, rest cut into pieces of lim bytes
            off  = sep + 1;
            rest = nal_len - 1;
            n    = 0;
            while (rest > 0) begin
               piece = (rest > lim) ? lim : rest;
               // start and end never share one fragment: split off the last byte
               if (n == 0 && piece == rest) piece = rest - 1;
               hdr = {3'b000, nal_hdr[4:0]};
               if (n == 0) hdr = hdr | FU_START_BIT;
               if (piece == rest) hdr = hdr | FU_END_BIT;
               push_packet(off, piece, FU_INDICATOR_BYTE, hdr, 1'b1, 1'b0, piece == rest);
               off  = off + piece;
               rest = rest - piece;
               n++;
            end
         end
         stamp_now = stamp_now + StampWidth'(stamp_step_reg);
      endfunction

      function string describe(packet_type p);
         return $sformatf(
            "seq=%0d stamp=%0d off=%0d len=%0d ind=%h hdr=%h frag=%b short=%b last=%b",
            p.seq, p.stamp, p.offset, p.length, p.fu_ind, p.fu_hdr,
            p.frag, p.too_short, p.last);
      endfunction

      // compare one accepted packet descriptor with the oldest one owed
      function void check_packet(logic [RspDataWidth-1:0] data, logic [RspUserWidth-1:0] user,
                                 logic last);
         packet_type got, want;
         got.seq       = data[15:0];
         got.stamp     = data[47:16];
         got.offset    = data[63:48];
         got.length    = data[74:64];
         got.fu_ind    = data[82:75];
         got.fu_hdr    = data[90:83];
         got.frag      = user[0];
         got.too_short = user[1];
         got.last      = last;
         if (owed.size() == 0) begin
            failures++;
            if (failures <= ShowLimit) $display("unexpected packet: %s", describe(got));
            return;
         end
         want = owed.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= ShowLimit) begin
               $display("packet mismatch at %0t", $realtime);
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction
   endclass

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [ReqDataWidth-1:0]   req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]   rsp_tdata;
   logic [RspUserWidth-1:0]   rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_we     = 1'b0;
   logic [CsrIdxWidth-1:0]    csr_index  = '0;
   logic [CsrDataWidth-1:0]   csr_wdata  = '0;

   // idling odds in percent, changed only between phases
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   packet_ledger_type ledger;

   h264_rtp_fua_packetizer #(
      .MAX_FRAME_BYTES(FrameCap)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [16:0] frame_length, [56:17] head_bytes
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] seq, [47:16] stamp, [63:48] offset,
                                 // [74:64] length, [82:75] fu ind, [90:83] fu hdr
      .rsp_tuser  (rsp_tuser),   // [0] fragmented, [1] too_short
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         ledger.note_frame(req_tdata[16:0], req_tdata[56:17]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_packet(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // watchdog: too long without any transaction means the block hung
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("** h264_rtp_fua_packetizer: FAILED **");
      $finish;
   end

   // one frame transaction, with random sender idling in front of it;
   // valid stays high on return so the next frame can follow back to back
   task automatic send_frame(input logic [LenWidth-1:0] flen, input logic [HeadWidth-1:0] head);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataWidth-LenWidth-HeadWidth){1'b0}}, head, flen};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // hold until every planned packet has come out
   task automatic wait_drain();
      while (ledger.owed.size() != 0) @(negedge clock);
   endtask

   // register write, only while the block is idle
   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      ledger.write_reg(idx, value);
   endtask

   initial begin : stimulus
      int unsigned          flen_r, sep_r, pick;
      logic [HeadWidth-1:0] head_r;

      ledger = new();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed frames at the reset settings (max payload 1300)
      send_frame(17'd0,     40'h00_0000_0000);   // empty frame
      send_frame(17'd4,     40'hFF_FFFF_FFFF);   // one byte short
      send_frame(17'd1,     40'h00_0000_0165);
      send_frame(17'd5,     40'h00_0000_0165);   // smallest frame, 4-byte start code
      send_frame(17'd5,     40'h00_0001_6742);   // smallest frame, 3-byte start code
      send_frame(17'd1304,  40'h00_0000_0141);   // nal exactly max payload
      send_frame(17'd1305,  40'h00_0000_0165);   // one byte over: lone fragment split
      send_frame(17'd1303,  40'h00_0001_4101);   // 3-byte code, exactly max payload
      send_frame(17'd1304,  40'h00_0001_65FF);   // 3-byte code, lone fragment split
      send_frame(17'd2605,  40'h00_0000_0165);   // two full fragments
      send_frame(17'd2606,  40'h00_0000_0106);   // two full fragments plus one byte
      send_frame(17'd65536, 40'h00_0000_0165);   // largest frame
      send_frame(17'd65537, 40'h00_0000_017C);   // just over the frame cap
      send_frame(17'h1FFFF, 40'hFF_FFFF_FFFF);   // all ones, nal type 31
      send_frame(17'd6,     40'h00_0000_0200);   // near-miss of the long start code
      send_frame(17'd6,     40'h01_0000_0165);   // nonzero leading byte
      send_frame(17'd3,     40'h00_0000_0165);   // short frame after long ones
      // sender holds off until the block has emptied
      go_quiet();
      wait_drain();

      // random phases, each with its own register settings and idling mix
      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            1: begin
               write_csr(CSR_MAX_PAYLOAD, 16'h0000);     // clamps up to the minimum
               write_csr(CSR_TIMESTAMP_STEP, 16'h0000);
            end
            2: begin
               write_csr(CSR_MAX_PAYLOAD, 16'hFFFF);     // clamps down to the maximum
               write_csr(CSR_TIMESTAMP_STEP, 16'hFFFF);
            end
            3: begin
               write_csr(CSR_MAX_PAYLOAD, 16'd1100);
               write_csr(CSR_TIMESTAMP_STEP, 16'($urandom()));
            end
            4: begin
               write_csr(CSR_MAX_PAYLOAD, 16'd1400);
               write_csr(CSR_TIMESTAMP_STEP, 16'd1);
            end
            5: begin
               write_csr(CSR_MAX_PAYLOAD, 16'd1099);
               write_csr(CSR_TIMESTAMP_STEP, 16'($urandom()));
            end
            6: begin
               write_csr(CSR_MAX_PAYLOAD, 16'd1401);
               write_csr(CSR_TIMESTAMP_STEP, 16'd3750);
            end
            7: begin
               write_csr(CSR_MAX_PAYLOAD, 16'($urandom_range(1400, 1100)));
               write_csr(CSR_TIMESTAMP_STEP, 16'($urandom()));
            end
            default: ;
         endcase
         // none, sender idle, receiver stall, both lightly
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase

         repeat (38) begin
            // now and then let the block run dry before the next frame
            if ($urandom_range(29) == 0) begin
               go_quiet();
               wait_drain();
            end
            // mostly proper start codes with random nal header bytes
            pick = $urandom_range(99);
            if (pick < 60) begin
               head_r[39:8] = 32'h0000_0001;
               head_r[7:0]  = 8'($urandom());
            end else if (pick < 85) begin
               head_r[39:16] = 24'h00_0001;
               head_r[15:0]  = 16'($urandom());
            end else begin
               head_r[39:8] = $urandom();
               head_r[7:0]  = 8'($urandom());
            end
            sep_r = (head_r[39:8] == 32'h0000_0001) ? 4 : 3;
            // sizes weighted to small frames and to fragment boundaries
            pick = $urandom_range(99);
            if (pick < 8)       flen_r = $urandom_range(4, 0);
            else if (pick < 45) flen_r = $urandom_range(3000, 5);
            else if (pick < 65) flen_r = sep_r + $urandom_range(5, 1) * ledger.payload_limit()
                                         + $urandom_range(3, 0) - 1;
            else if (pick < 85) flen_r = $urandom_range(20000, 3001);
            else if (pick < 93) flen_r = $urandom_range(65536, 60000);
            else                flen_r = $urandom_range(131071, 65537);
            send_frame(flen_r[LenWidth-1:0], head_r);
         end
         go_quiet();
         wait_drain();
      end

      // all frames in: wait for the last packets, then a short settle
      go_quiet();
      wait_drain();
      repeat (16) @(negedge clock);
      if (ledger.failures == 0 && ledger.owed.size() == 0) begin
         $display("** h264_rtp_fua_packetizer: PASSED **");
      end else begin
         $display("** h264_rtp_fua_packetizer: FAILED **");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/fua_pkg.sv
hdl/fua_front.sv
hdl/fua_queue.sv
hdl/fua_back.sv
hdl/h264_rtp_fua_packetizer.sv
sim/tb.sv
